FILE: rtl/bel_pkg.sv
// Shared types and constants for the byte escape / line fold filter.
// No dependencies; every other file imports this package.
package bel_pkg;

    localparam int LIMIT_W    = 10;
    localparam int BCOL_W     = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int Q_DEPTH    = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEX_MODE   = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 10'd80;
    localparam logic [BCOL_W-1:0]  HDR_RESTART   = 11'd15;
    localparam logic [BCOL_W-1:0]  ESC_WIDTH     = 11'd4;

    localparam logic [7:0] CH_NL = 8'h0A;

    // body kinds of a queued job
    localparam logic [1:0] BODY_NONE = 2'd0;
    localparam logic [1:0] BODY_CHAR = 2'd1;
    localparam logic [1:0] BODY_HEX  = 2'd2;
    localparam logic [1:0] BODY_OCT  = 2'd3;

    typedef struct packed {
        logic       lead_nl;  // newline before anything else
        logic       header;   // header text after the lead newline
        logic [1:0] body;
        logic [7:0] ch;
        logic       fold_nl;  // newline after a folded text line
    } t_job;

endpackage

FILE: rtl/bel_if.sv
// Handshake channels of the byte escape / line fold filter.
// Depends on bel_pkg for the configuration widths.
interface bel_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] in_byte;

    modport source (output valid, output kind, output in_byte, input ready);
    modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

interface bel_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

interface bel_cfg_if
    import bel_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/bel_front.sv
// Front end: accepts input beats, tracks the text and binary columns and
// turns each item into a job descriptor. Depends on bel_pkg and bel_if.
module bel_front
    import bel_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    bel_in_if.sink             i_in,
    input  logic [LIMIT_W-1:0] i_line_limit,
    input  logic               i_hex_mode,
    input  logic               i_full,
    output logic               o_push,
    output t_job               o_job
);

    logic [LIMIT_W-1:0] r_text;
    logic [LIMIT_W-1:0] n_text;
    logic [BCOL_W-1:0]  r_bin;
    logic [BCOL_W-1:0]  n_bin;
    logic [LIMIT_W-1:0] text_inc;
    logic [BCOL_W-1:0]  bin_base;
    logic               printable;
    logic               need_hdr;
    t_job               job;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign o_job      = job;

    assign printable = (i_in.in_byte >= 8'h20 && i_in.in_byte <= 8'h7E)
                    || (i_in.in_byte >= 8'h09 && i_in.in_byte <= 8'h0D);
    assign need_hdr  = (r_text != '0)
                    || ({1'b0, r_bin} + {1'b0, ESC_WIDTH} >= {2'b00, i_line_limit});

    always_comb begin
        job      = '0;
        job.ch   = i_in.in_byte;
        job.body = BODY_NONE;
        n_text   = r_text;
        n_bin    = r_bin;
        text_inc = '0;
        bin_base = r_bin;
        if (i_in.kind) begin
            job.lead_nl = 1'b1;
            n_text      = '0;
            n_bin       = '0;
        end else if (printable) begin
            job.body = BODY_CHAR;
            if (r_bin != '0) begin
                job.lead_nl = 1'b1;
                text_inc    = LIMIT_W'(1);
            end else begin
                text_inc = r_text + LIMIT_W'(1);
            end
            if (i_in.in_byte == CH_NL) begin
                text_inc = '0;
            end
            if (text_inc == i_line_limit) begin
                job.fold_nl = 1'b1;
                text_inc    = '0;
            end
            n_text = text_inc;
            n_bin  = '0;
        end else begin
            job.body = i_hex_mode ? BODY_HEX : BODY_OCT;
            if (need_hdr) begin
                job.lead_nl = 1'b1;
                job.header  = 1'b1;
                n_text      = '0;
                bin_base    = HDR_RESTART;
            end
            n_bin = bin_base + ESC_WIDTH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text <= '0;
            r_bin  <= '0;
        end else if (o_push) begin
            r_text <= n_text;
            r_bin  <= n_bin;
        end
    end

endmodule

FILE: rtl/bel_queue.sv
// Short job queue between front and back end.
// Depends on bel_pkg for the job type.
module bel_queue
    import bel_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_pop_data,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/bel_back.sv
// Back end: expands one job into its characters, one per cycle while the
// output is ready, through an output register. Depends on bel_pkg and bel_if.
module bel_back
    import bel_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_job i_job,
    output logic o_pop,
    bel_out_if.source o_out
);

    localparam logic [1:0] PH_LEAD = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_FOLD = 2'd3;
    localparam logic [3:0] HDR_LAST = 4'd14;

    function automatic logic [7:0] hdr_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "B";
            4'd1:    c = "i";
            4'd2:    c = "n";
            4'd3:    c = "a";
            4'd4:    c = "r";
            4'd5:    c = "y";
            4'd6:    c = " ";
            4'd7:    c = "S";
            4'd8:    c = "t";
            4'd9:    c = "r";
            4'd10:   c = "e";
            4'd11:   c = "a";
            4'd12:   c = "m";
            4'd13:   c = ":";
            default: c = " ";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else begin
            c = 8'h37 + {4'h0, nib};
        end
        return c;
    endfunction

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_phase;
    logic [3:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    logic [7:0] cur_char;
    logic [7:0] body_char;
    logic [3:0] body_last;
    logic       has_next;
    logic [1:0] nx_phase;
    logic [3:0] nx_idx;
    logic [1:0] first_phase;
    logic       out_take;
    logic       load;

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.last     = r_out_last;

    assign out_take = !r_out_valid || o_out.ready;
    assign load     = !i_empty && (!r_busy || (out_take && !has_next));
    assign o_pop    = load;

    assign first_phase = i_job.lead_nl ? PH_LEAD
                       : ((i_job.body != BODY_NONE) ? PH_BODY : PH_FOLD);

    // digit of the escape or the echoed byte
    always_comb begin
        body_char = r_job.ch;
        body_last = 4'd0;
        unique case (r_job.body)
            BODY_HEX: begin
                body_last = 4'd1;
                body_char = (r_idx == 4'd0) ? hex_char(r_job.ch[7:4])
                                            : hex_char(r_job.ch[3:0]);
            end
            BODY_OCT: begin
                body_last = 4'd2;
                priority if (r_idx == 4'd0) begin
                    body_char = (r_job.ch[7:6] != 2'd0) ? 8'h30 + {6'd0, r_job.ch[7:6]} : " ";
                end else if (r_idx == 4'd1) begin
                    body_char = (r_job.ch[7:3] != 5'd0) ? 8'h30 + {5'd0, r_job.ch[5:3]} : " ";
                end else begin
                    body_char = 8'h30 + {5'd0, r_job.ch[2:0]};
                end
            end
            default: begin
                body_char = r_job.ch;
                body_last = 4'd0;
            end
        endcase
    end

    always_comb begin
        cur_char = CH_NL;
        has_next = 1'b0;
        nx_phase = r_phase;
        nx_idx   = '0;
        unique case (r_phase)
            PH_LEAD: begin
                cur_char = CH_NL;
                if (r_job.header) begin
                    has_next = 1'b1;
                    nx_phase = PH_HDR;
                end else if (r_job.body != BODY_NONE) begin
                    has_next = 1'b1;
                    nx_phase = PH_BODY;
                end else if (r_job.fold_nl) begin
                    has_next = 1'b1;
                    nx_phase = PH_FOLD;
                end
            end
            PH_HDR: begin
                cur_char = hdr_char(r_idx);
                has_next = 1'b1;
                if (r_idx == HDR_LAST) begin
                    nx_phase = PH_BODY;
                end else begin
                    nx_idx = r_idx + 4'd1;
                end
            end
            PH_BODY: begin
                cur_char = body_char;
                if (r_idx != body_last) begin
                    has_next = 1'b1;
                    nx_idx   = r_idx + 4'd1;
                end else if (r_job.fold_nl) begin
                    has_next = 1'b1;
                    nx_phase = PH_FOLD;
                end
            end
            PH_FOLD: begin
                cur_char = CH_NL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_busy) begin
            r_out_char <= cur_char;
            r_out_last <= !has_next;
        end
        if (load) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_LEAD;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_take) begin
                r_out_valid <= r_busy;
            end
            priority if (load) begin
                r_busy  <= 1'b1;
                r_phase <= first_phase;
                r_idx   <= '0;
            end else if (r_busy && out_take && !has_next) begin
                r_busy <= 1'b0;
            end else if (r_busy && out_take) begin
                // advance to the next character of this job
                r_phase <= nx_phase;
                r_idx   <= nx_idx;
            end
        end
    end

endmodule

FILE: rtl/byte_escape_line_folder.sv
// Byte escape / line fold filter. Each input beat carries one byte (or an end
// of stream mark) and yields 1 to 19 output characters, the final one flagged
// with last: one for plain text, plus a leading newline when it closes a binary
// run and a trailing newline when it folds the line (up to three), 2 or 3
// escape digits for a non-printable byte, plus 16 when a "Binary Stream: "
// header line opens a run. The front end takes one input
// beat per cycle while its QUEUE_DEPTH-entry job queue has room; the back end
// character generator sends one character per cycle through its output
// register while the output is ready, and takes the next job from the queue
// as it sends the last character of the current one. The first character
// passes the job queue, job register and output register. Configuration
// (line_limit, hex_mode) is written through the cfg channel, always ready.
module byte_escape_line_folder
    import bel_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bel_in_if.sink     i_in,
    bel_out_if.source  o_out,
    bel_cfg_if.sink    i_cfg
);

    logic [LIMIT_W-1:0] r_line_limit;
    logic               r_hex_mode;
    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    t_job               push_job;
    t_job               pop_job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= LIMIT_RESET;
            r_hex_mode   <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_LINE_LIMIT: r_line_limit <= i_cfg.data[LIMIT_W-1:0];
                CFG_HEX_MODE:   r_hex_mode   <= i_cfg.data[0];
            endcase
        end
    end

    bel_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_line_limit (r_line_limit),
        .i_hex_mode   (r_hex_mode),
        .i_full       (full),
        .o_push       (push),
        .o_job        (push_job)
    );

    bel_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_job),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_job),
        .o_empty     (empty)
    );

    bel_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (pop_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: dv/byte_escape_line_folder_test.sv
// Self-checking bench for byte_escape_line_folder: random beats on the input,
// random backpressure on the output, config writes between drained phases.
// Depends on bel_pkg and the bel_*_if interfaces from the RTL.
`timescale 1ns / 100ps

module byte_escape_line_folder_test;
    import bel_pkg::*;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam int         HDR_LEN  = 15;
    localparam logic [8*HDR_LEN-1:0] HDR_TEXT = "Binary Stream: ";

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } beat_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    logic i_clk;
    logic i_rst_n;

    bel_in_if  in_ch();
    bel_out_if out_ch();
    bel_cfg_if cfg_ch();

    byte_escape_line_folder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    beat_t byte_beats[$];
    char_t chars_due[$];
    int    beats_offered = 0;
    int    beats_taken   = 0;
    int    mismatches    = 0;

    // shadow of the filter's registers and columns
    logic [LIMIT_W-1:0] lim      = LIMIT_RESET;
    logic               hex_on   = 1'b0;
    logic [LIMIT_W-1:0] text_col = '0;
    logic [BCOL_W-1:0]  bin_col  = '0;

    int src_gap  = 0;
    int src_calm = 0;
    int snk_gap  = 0;
    int snk_calm = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic is_text(input logic [7:0] b);
        return (b >= 8'h20 && b <= 8'h7E) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        return (d < 4'd10) ? CH_ZERO + 8'(d) : CH_UPPER + 8'(d) - 8'd10;
    endfunction

    // mostly back to back, sometimes a few cycles, rarely a long hold
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    task automatic escape_and_fold(input logic kind, input logic [7:0] b);
        logic [7:0] seq[$];
        logic [2:0] d2, d1, d0;
        if (kind == KIND_END) begin
            seq.push_back(CH_NL);
            text_col = '0;
            bin_col  = '0;
        end else if (is_text(b)) begin
            if (bin_col != 0) begin
                seq.push_back(CH_NL);
                bin_col  = '0;
                text_col = '0;
            end
            seq.push_back(b);
            text_col = text_col + 1'b1;
            if (b == CH_NL) text_col = '0;
            if (text_col == lim) begin
                seq.push_back(CH_NL);
                text_col = '0;
            end
        end else begin
            if (text_col != 0 || 32'(bin_col) + 32'(ESC_WIDTH) >= 32'(lim)) begin
                seq.push_back(CH_NL);
                for (int i = 0; i < HDR_LEN; i++)
                    seq.push_back(HDR_TEXT[8*(HDR_LEN-1-i) +: 8]);
                text_col = '0;
                bin_col  = HDR_RESTART;
            end
            if (hex_on) begin
                seq.push_back(hex_char(b[7:4]));
                seq.push_back(hex_char(b[3:0]));
            end else begin
                d2 = {1'b0, b[7:6]};
                d1 = b[5:3];
                d0 = b[2:0];
                seq.push_back((d2 != 0) ? CH_ZERO + 8'(d2) : CH_SPACE);
                seq.push_back((d2 != 0 || d1 != 0) ? CH_ZERO + 8'(d1) : CH_SPACE);
                seq.push_back(CH_ZERO + 8'(d0));
            end
            bin_col = bin_col + ESC_WIDTH;
        end
        foreach (seq[i])
            chars_due.push_back('{ch: seq[i], last: (i == seq.size() - 1)});
    endtask

    task automatic add_beat(input logic kind, input logic [7:0] b);
        byte_beats.push_back('{kind: kind, data: b});
    endtask

    function automatic logic [7:0] binary_byte();
        int v;
        v = $urandom_range(0, 155);
        if (v < 9) return 8'(v);
        if (v < 27) return 8'(v - 9 + 14);
        return 8'(v - 27 + 127);
    endfunction

    // runs of text, runs of escapes, raw noise and end marks
    task automatic add_random_beats(input int n);
        int cnt, sort, len;
        logic [7:0] b;
        cnt = 0;
        while (cnt < n) begin
            sort = $urandom_range(0, 9);
            len  = (sort == 9) ? 1 : $urandom_range(1, 8);
            for (int k = 0; k < len && cnt < n; k++) begin
                if (sort <= 3) begin
                    if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(9, 13));
                    else b = 8'($urandom_range(32, 126));
                    add_beat(KIND_DATA, b);
                end else if (sort <= 6) begin
                    add_beat(KIND_DATA, binary_byte());
                end else if (sort <= 8) begin
                    add_beat(KIND_DATA, 8'($urandom_range(0, 255)));
                end else begin
                    add_beat(KIND_END, 8'($urandom_range(0, 255)));
                end
                cnt++;
            end
        end
    endtask

    // hold until every queued beat is taken and every char has come out
    task automatic settle();
        while (byte_beats.size() != 0 || beats_offered != beats_taken ||
               chars_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // input driver
    always @(negedge i_clk) begin
        logic  drive_next;
        beat_t nb;
        drive_next = 1'b0;
        nb = '0;
        if (!(in_ch.valid && beats_taken != beats_offered)) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (byte_beats.size() != 0) begin
                nb = byte_beats.pop_front();
                drive_next = 1'b1;
                beats_offered++;
                if (src_calm > 0) begin
                    src_calm--;
                    src_gap = 0;
                end else begin
                    src_gap = pick_gap();
                    if ($urandom_range(0, 49) == 0) src_calm = $urandom_range(10, 40);
                end
            end
            in_ch.valid <= drive_next;
            if (drive_next) begin
                in_ch.kind    <= nb.kind;
                in_ch.in_byte <= nb.data;
            end
        end
    end

    // output backpressure
    always @(negedge i_clk) begin
        if (snk_gap > 0) begin
            out_ch.ready <= 1'b0;
            snk_gap--;
        end else begin
            out_ch.ready <= 1'b1;
            if (snk_calm > 0) begin
                snk_calm--;
            end else begin
                snk_gap = pick_gap();
                if ($urandom_range(0, 49) == 0) snk_calm = $urandom_range(10, 40);
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        char_t due;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_LINE_LIMIT: lim = cfg_ch.data[LIMIT_W-1:0];
                    CFG_HEX_MODE:   hex_on = cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                beats_taken++;
                escape_and_fold(in_ch.kind, in_ch.in_byte);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (chars_due.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual char %h last %b",
                             $time, out_ch.out_char, out_ch.last);
                    mismatches++;
                end else begin
                    due = chars_due.pop_front();
                    if (out_ch.out_char !== due.ch) begin
                        $display("%0t: out_char expected %h actual %h",
                                 $time, due.ch, out_ch.out_char);
                        mismatches++;
                    end
                    if (out_ch.last !== due.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $time, due.last, out_ch.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        logic [LIMIT_W-1:0] new_lim;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.kind     = KIND_DATA;
        in_ch.in_byte  = 8'h00;
        out_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_LINE_LIMIT;
        cfg_ch.data    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: octal escapes, limit 80
        add_beat(KIND_DATA, 8'h00);     // first escape after reset, no header
        add_beat(KIND_DATA, 8'h01);
        add_beat(KIND_DATA, 8'h08);
        add_beat(KIND_DATA, 8'h0E);
        add_beat(KIND_DATA, 8'h1F);
        add_beat(KIND_DATA, 8'h7F);
        add_beat(KIND_DATA, 8'h80);
        add_beat(KIND_DATA, 8'hFF);
        add_beat(KIND_DATA, 8'h41);     // text closes the binary run
        add_beat(KIND_DATA, 8'h09);
        add_beat(KIND_DATA, 8'h0D);
        add_beat(KIND_DATA, 8'h20);
        add_beat(KIND_DATA, 8'h7E);
        add_beat(KIND_DATA, CH_NL);
        add_beat(KIND_DATA, 8'h78);
        add_beat(KIND_DATA, 8'h1B);     // escape after text opens a header
        add_beat(KIND_END, 8'hFF);
        add_beat(KIND_END, 8'h00);
        settle();

        // narrowest line, hex escapes: every char but the newline folds, every escape headed
        write_reg(CFG_LINE_LIMIT, CFG_DATA_W'(1));
        write_reg(CFG_HEX_MODE, CFG_DATA_W'(1));
        add_beat(KIND_DATA, 8'h61);
        add_beat(KIND_DATA, CH_NL);
        add_beat(KIND_DATA, 8'h00);
        add_beat(KIND_DATA, 8'hA5);
        add_beat(KIND_DATA, 8'h62);
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       new_lim = LIMIT_W'($urandom_range(1, 4));
                1:       new_lim = LIMIT_W'($urandom_range(5, 30));
                2:       new_lim = LIMIT_RESET;
                3:       new_lim = 10'd1023;
                default: new_lim = LIMIT_W'($urandom_range(31, 200));
            endcase
            write_reg(CFG_LINE_LIMIT, CFG_DATA_W'(new_lim));
            write_reg(CFG_HEX_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            add_random_beats(30);
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("[byte_escape_line_folder] OK");
        else
            $display("[byte_escape_line_folder] ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[byte_escape_line_folder] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bel_pkg.sv
rtl/bel_if.sv
rtl/bel_front.sv
rtl/bel_queue.sv
rtl/bel_back.sv
rtl/byte_escape_line_folder.sv
dv/byte_escape_line_folder_test.sv
